// ===== hw/rtl/pss_pkg.sv =====
// Shared types and constants for the positional sequence store.
// Holds list depth, derived widths, command and status codes, word structs.
// No dependencies.
package pss_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CTR_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_REMOVE  = 3'd1;
    localparam logic [2:0] CMD_MOVE    = 3'd2;
    localparam logic [2:0] CMD_DUMP    = 3'd3;
    localparam logic [2:0] CMD_REVERSE = 3'd4;
    localparam logic [2:0] CMD_ROTL    = 3'd5;
    localparam logic [2:0] CMD_ROTR    = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]        cmd;
        logic signed [31:0] value;
        logic [5:0]        pos_a;
        logic [5:0]        pos_b;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic               last;
        logic               empty_list;
        logic [1:0]         status;
    } res_word_t;

    // Window shift request from the sequencer
    typedef struct packed {
        logic              act;
        logic              left;
        logic              load;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [DATA_W-1:0] load_val;
    } shift_req_t;

    // Broadcast control seen by every cell
    typedef struct packed {
        logic              act;
        logic              left;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [DATA_W-1:0] wrap_val;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/pss_cell.sv =====
// One storage cell of the list chain.
// Takes a neighbor's value or the wrap value when inside the shift window.
// Depends on pss_pkg.
module pss_cell
(
    input  logic                       clk,
    input  logic [pss_pkg::IDX_W-1:0]  idx,
    input  pss_pkg::cell_ctl_t         ctl,
    input  logic [pss_pkg::DATA_W-1:0] prev_val,
    input  logic [pss_pkg::DATA_W-1:0] next_val,
    output logic [pss_pkg::DATA_W-1:0] val
);

    logic [pss_pkg::DATA_W-1:0] val_reg;
    logic [pss_pkg::DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.act)
        begin
            if (ctl.left)
            begin
                // shift toward position 0, wrap enters at the top of the window
                if (idx == ctl.hi)
                    val_next = ctl.wrap_val;
                else if (idx >= ctl.lo && idx < ctl.hi)
                    val_next = next_val;
            end
            else
            begin
                // shift away from position 0, wrap enters at the bottom
                if (idx == ctl.lo)
                    val_next = ctl.wrap_val;
                else if (idx > ctl.lo && idx <= ctl.hi)
                    val_next = prev_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== hw/rtl/pss_ctrl.sv =====
// Command sequencer and result register for the positional sequence store.
// Decodes commands, checks positions, issues window shifts to the cell chain.
// Depends on pss_pkg.
module pss_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  pss_pkg::cmd_word_t         cmd_word,
    output logic                       res_valid,
    input  logic                       res_ready,
    output pss_pkg::res_word_t         res_word,
    input  logic [pss_pkg::DATA_W-1:0] head_val,
    output pss_pkg::shift_req_t        req
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_STEP   = 5'b00100,
        S_DUMP   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    localparam logic [1:0] MODE_REV  = 2'd0;
    localparam logic [1:0] MODE_ROTL = 2'd1;
    localparam logic [1:0] MODE_ROTR = 2'd2;

    state_t                      state_reg, state_next;
    pss_pkg::cmd_word_t          cmd_reg, cmd_next;
    logic [pss_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [pss_pkg::CTR_W-1:0]   ctr_reg, ctr_next;
    logic [1:0]                  mode_reg, mode_next;
    logic [1:0]                  status_reg, status_next;
    logic                        empty_reg, empty_next;
    logic                        res_valid_reg, res_valid_next;
    pss_pkg::res_word_t          res_reg, res_next;

    logic [pss_pkg::CTR_W-1:0]   pa_x;
    logic [pss_pkg::CTR_W-1:0]   pb_x;
    logic [pss_pkg::CTR_W-1:0]   n_x;
    logic [pss_pkg::CTR_W-1:0]   last_ctr;
    logic [pss_pkg::IDX_W-1:0]   last_idx;
    logic                        out_free;
    logic                        dump_last;

    assign pa_x      = pss_pkg::CTR_W'(cmd_reg.pos_a);
    assign pb_x      = pss_pkg::CTR_W'(cmd_reg.pos_b);
    assign n_x       = pss_pkg::CTR_W'(count_reg);
    assign last_ctr  = n_x - pss_pkg::CTR_W'(1);
    assign last_idx  = last_ctr[pss_pkg::IDX_W-1:0];
    assign out_free  = !res_valid_reg || res_ready;
    assign dump_last = (ctr_reg == last_ctr);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        ctr_next       = ctr_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        empty_next     = empty_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        req            = '0;
        req.load_val   = cmd_reg.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_word;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                empty_next  = (count_reg == '0);
                status_next = pss_pkg::ST_OK;
                state_next  = S_FINISH;
                case (cmd_reg.cmd)
                    pss_pkg::CMD_INSERT:
                    begin
                        if (count_reg == pss_pkg::CNT_W'(pss_pkg::DEPTH))
                            status_next = pss_pkg::ST_FULL;
                        else if (pa_x > n_x)
                            status_next = pss_pkg::ST_BADPOS;
                        else
                        begin
                            req.act    = 1'b1;
                            req.load   = 1'b1;
                            req.lo     = cmd_reg.pos_a[pss_pkg::IDX_W-1:0];
                            req.hi     = count_reg[pss_pkg::IDX_W-1:0];
                            count_next = count_reg + pss_pkg::CNT_W'(1);
                        end
                    end

                    pss_pkg::CMD_REMOVE:
                    begin
                        if (count_reg == '0)
                            status_next = pss_pkg::ST_EMPTY;
                        else if (pa_x >= n_x)
                            status_next = pss_pkg::ST_BADPOS;
                        else
                        begin
                            req.act    = 1'b1;
                            req.left   = 1'b1;
                            req.lo     = cmd_reg.pos_a[pss_pkg::IDX_W-1:0];
                            req.hi     = last_idx;
                            count_next = count_reg - pss_pkg::CNT_W'(1);
                        end
                    end

                    pss_pkg::CMD_MOVE:
                    begin
                        if (count_reg == '0)
                            status_next = pss_pkg::ST_EMPTY;
                        else if (pa_x >= n_x || pb_x >= n_x)
                            status_next = pss_pkg::ST_BADPOS;
                        else if (pa_x <= pb_x)
                        begin
                            req.act  = 1'b1;
                            req.left = 1'b1;
                            req.lo   = cmd_reg.pos_a[pss_pkg::IDX_W-1:0];
                            req.hi   = cmd_reg.pos_b[pss_pkg::IDX_W-1:0];
                        end
                        else
                        begin
                            req.act = 1'b1;
                            req.lo  = cmd_reg.pos_b[pss_pkg::IDX_W-1:0];
                            req.hi  = cmd_reg.pos_a[pss_pkg::IDX_W-1:0];
                        end
                    end

                    pss_pkg::CMD_DUMP:
                    begin
                        if (count_reg == '0)
                            status_next = pss_pkg::ST_EMPTY;
                        else
                        begin
                            ctr_next   = '0;
                            state_next = S_DUMP;
                        end
                    end

                    pss_pkg::CMD_REVERSE:
                    begin
                        if (count_reg == '0)
                            status_next = pss_pkg::ST_EMPTY;
                        else
                        begin
                            ctr_next   = last_ctr;
                            mode_next  = MODE_REV;
                            state_next = S_STEP;
                        end
                    end

                    pss_pkg::CMD_ROTL:
                    begin
                        if (count_reg == '0)
                            status_next = pss_pkg::ST_EMPTY;
                        else
                        begin
                            ctr_next   = pa_x;
                            mode_next  = MODE_ROTL;
                            state_next = S_STEP;
                        end
                    end

                    pss_pkg::CMD_ROTR:
                    begin
                        if (count_reg == '0)
                            status_next = pss_pkg::ST_EMPTY;
                        else
                        begin
                            ctr_next   = pa_x;
                            mode_next  = MODE_ROTR;
                            state_next = S_STEP;
                        end
                    end

                    default:
                    begin
                        status_next = pss_pkg::ST_OK;
                    end
                endcase
            end

            S_STEP:
            begin
                if (ctr_reg == '0)
                    state_next = S_FINISH;
                else
                begin
                    ctr_next = ctr_reg - pss_pkg::CTR_W'(1);
                    case (mode_reg)
                        MODE_REV:
                        begin
                            // move the head to the top of a shrinking window
                            req.act  = 1'b1;
                            req.left = 1'b1;
                            req.hi   = ctr_reg[pss_pkg::IDX_W-1:0];
                        end
                        MODE_ROTL:
                        begin
                            req.act  = 1'b1;
                            req.left = 1'b1;
                            req.hi   = last_idx;
                        end
                        MODE_ROTR:
                        begin
                            req.act = 1'b1;
                            req.hi  = last_idx;
                        end
                        default:
                        begin
                            req.act = 1'b0;
                        end
                    endcase
                end
            end

            S_DUMP:
            begin
                if (out_free)
                begin
                    // emit the head and rotate it to the tail
                    req.act                = 1'b1;
                    req.left               = 1'b1;
                    req.hi                 = last_idx;
                    res_valid_next         = 1'b1;
                    res_next.data_out      = head_val;
                    res_next.last          = dump_last;
                    res_next.empty_list    = 1'b0;
                    res_next.status        = pss_pkg::ST_OK;
                    ctr_next               = ctr_reg + pss_pkg::CTR_W'(1);
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next      = 1'b1;
                    res_next.data_out   = '0;
                    res_next.last       = 1'b1;
                    res_next.empty_list = empty_reg;
                    res_next.status     = status_reg;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ctr_reg    <= ctr_next;
        mode_reg   <= mode_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
        res_reg    <= res_next;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

endmodule

// ===== hw/rtl/positional_sequence_store_top.sv =====
// Top level of the positional sequence store: sequencer plus a chain of cells.
// Depends on pss_pkg, pss_cell, pss_ctrl.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+---------------------
//   cmd     | in        | cmd_valid / cmd_ready | pss_pkg::cmd_word_t
//   res     | out       | res_valid / res_ready | pss_pkg::res_word_t
//
// One command word is taken at a time; the next one is taken only once the
// sequencer has returned to idle, as the last result word is loaded.
// Insert, remove, move, a failed command and the unused code go from decode
// straight to the status word. Reverse and the rotations first step the chain
// one window shift at a time, rotations by pos_a positions; dump emits one
// result word per stored entry, head first, the last one flagged. The chain
// moves at most one window step per cycle.
// Reset clears the entry count, so the list starts empty; cell contents are
// not cleared. A stalled result holds the sequencer in the finish and dump
// states; dump advances only when the result register is free.
module positional_sequence_store_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  pss_pkg::cmd_word_t cmd_word,
    output logic               res_valid,
    input  logic               res_ready,
    output pss_pkg::res_word_t res_word
);

    pss_pkg::shift_req_t        req;
    pss_pkg::cell_ctl_t         ctl;
    logic [pss_pkg::DATA_W-1:0] cell_val [pss_pkg::DEPTH];
    logic [pss_pkg::IDX_W-1:0]  wrap_idx;

    pss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word),
        .head_val  (cell_val[0]),
        .req       (req)
    );

    // Wrap value: the entry that leaves one end of the window re-enters at
    // the other end; on insert the new value enters instead.
    assign wrap_idx     = req.left ? req.lo : req.hi;
    assign ctl.act      = req.act;
    assign ctl.left     = req.left;
    assign ctl.lo       = req.lo;
    assign ctl.hi       = req.hi;
    assign ctl.wrap_val = req.load ? req.load_val : cell_val[wrap_idx];

    // Chain of cells: cell i sees cell i-1 and cell i+1. The end inputs are
    // never selected, since no window extends past either end.
    for (genvar g = 0; g < pss_pkg::DEPTH; g++)
    begin : g_cell
        logic [pss_pkg::DATA_W-1:0] prev_val;
        logic [pss_pkg::DATA_W-1:0] next_val;

        if (g == 0)
        begin : g_first
            assign prev_val = '0;
        end
        else
        begin : g_mid_lo
            assign prev_val = cell_val[g-1];
        end

        if (g == pss_pkg::DEPTH - 1)
        begin : g_last
            assign next_val = '0;
        end
        else
        begin : g_mid_hi
            assign next_val = cell_val[g+1];
        end

        pss_cell u_cell
        (
            .clk      (clk),
            .idx      (pss_pkg::IDX_W'(g)),
            .ctl      (ctl),
            .prev_val (prev_val),
            .next_val (next_val),
            .val      (cell_val[g])
        );
    end

endmodule
